[rtl/assert_macros.svh]
// Assertion macros used by the top level of the nearest-symbol grid search RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define NSGS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must be followed by a consequence in the next cycle.
`define NSGS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nsgs_pkg.sv]
// Package of the nearest-symbol grid search: types, codes and constants.
// No dependencies; the front end, command queue, scan engine and top level import it.
`timescale 1ns / 1ps

package nsgs_pkg;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GRID_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_GRID_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_DISTANCE_LIMIT = 2'd2;

    localparam logic [6:0] GRID_WIDTH_RESET     = 7'd64;
    localparam logic [6:0] GRID_HEIGHT_RESET    = 7'd64;
    localparam logic [9:0] DISTANCE_LIMIT_RESET = 10'd1000;

    localparam logic [6:0] DISTANCE_SAT = 7'd127;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    typedef struct packed {
        logic [6:0] grid_width;
        logic [6:0] grid_height;
        logic [9:0] distance_limit;
    } cfg_t;

    typedef struct packed {
        logic       kind;
        logic [5:0] col;
        logic [5:0] row;
        logic [7:0] symbol;
    } cmd_t;

    typedef struct packed {
        logic scanning;
        logic loading;
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } back_state_t;

endpackage

[rtl/nsgs_item_if.sv]
// Input channel of the grid search: write and query requests.
// Depends on nothing but the valid/ready handshake convention.
`timescale 1ns / 1ps

interface nsgs_item_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [7:0] symbol;

    modport source (output valid, output kind, output col, output row, output symbol,
                    input ready);
    modport sink (input valid, input kind, input col, input row, input symbol,
                  output ready);
endinterface

[rtl/nsgs_result_if.sv]
// Output channel of the grid search: one result request per query.
// Depends on nothing but the valid/ready handshake convention.
`timescale 1ns / 1ps

interface nsgs_result_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [5:0] match_col;
    logic [5:0] match_row;
    logic [6:0] match_distance;

    modport source (output valid, output found, output match_col, output match_row,
                    output match_distance, input ready);
    modport sink (input valid, input found, input match_col, input match_row,
                  input match_distance, output ready);
endinterface

[rtl/nsgs_front.sv]
// Front end: accepts requests, drops writes that fall outside storage, and
// pushes the rest into the command queue. Depends on nsgs_pkg and nsgs_item_if.
`timescale 1ns / 1ps

module nsgs_front
    import nsgs_pkg::*;
#(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64
)
(
    nsgs_item_if.sink item,
    input  logic      q_full,
    output logic      q_push,
    output cmd_t      q_data
);

    localparam logic [8:0] MAX_W9 = 9'(MAX_W);
    localparam logic [8:0] MAX_H9 = 9'(MAX_H);

    logic accept;
    logic in_store;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;
    assign in_store   = ({3'b000, item.col} < MAX_W9) && ({3'b000, item.row} < MAX_H9);
    assign q_push     = accept && ((item.kind == KIND_QUERY) || in_store);

    always_comb
    begin
        q_data.kind   = item.kind;
        q_data.col    = item.col;
        q_data.row    = item.row;
        q_data.symbol = item.symbol;
    end

endmodule

[rtl/nsgs_cmd_fifo.sv]
// Short command queue between the front end and the scan engine.
// Depends on nsgs_pkg for the command type and depth.
`timescale 1ns / 1ps

module nsgs_cmd_fifo
    import nsgs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;

    assign full     = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/nsgs_back.sv]
// Scan engine: holds the grid memory, performs writes and raster scans
// for queries, and drives the result register. Depends on nsgs_pkg, nsgs_result_if.
`timescale 1ns / 1ps

module nsgs_back
    import nsgs_pkg::*;
#(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  cmd_t       cmd,
    input  logic       cmd_empty,
    output logic       cmd_pop,
    nsgs_result_if.source result,
    output status_t    status
);

    localparam int CW    = (MAX_W > 1) ? $clog2(MAX_W) : 1;
    localparam int RW    = (MAX_H > 1) ? $clog2(MAX_H) : 1;
    localparam int AW    = CW + RW;
    localparam int DEPTH = 1 << AW;
    localparam logic [8:0] MAX_W9 = 9'(MAX_W);
    localparam logic [8:0] MAX_H9 = 9'(MAX_H);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;

    back_state_t state_reg, state_next;
    logic [5:0] col_reg, col_next;
    logic [5:0] row_reg, row_next;
    logic [7:0] sym_reg, sym_next;
    logic [7:0] last_c_reg, last_c_next;
    logic [7:0] last_r_reg, last_r_next;
    logic [7:0] c_reg, c_next;
    logic [7:0] r_reg, r_next;
    logic       s1_valid_reg, s1_valid_next;
    logic [8:0] s1_dist_reg, s1_dist_next;
    logic [7:0] s1_c_reg, s1_c_next;
    logic [7:0] s1_r_reg, s1_r_next;
    logic [9:0] best_dist_reg, best_dist_next;
    logic [7:0] best_c_reg, best_c_next;
    logic [7:0] best_r_reg, best_r_next;
    logic       hit_reg, hit_next;
    logic       out_valid_reg, out_valid_next;
    logic       found_reg, found_next;
    logic [5:0] match_col_reg, match_col_next;
    logic [5:0] match_row_reg, match_row_next;
    logic [6:0] match_dist_reg, match_dist_next;

    logic [8:0] w9;
    logic [8:0] h9;
    logic       grid_empty;
    logic [7:0] dc;
    logic [7:0] dr;
    logic [8:0] scan_dist;
    logic [8:0] c9;
    logic [8:0] r9;
    logic [8:0] wc9;
    logic [8:0] wr9;
    logic       match;
    logic       load;

    assign w9 = ({2'b00, cfg.grid_width} > MAX_W9) ? MAX_W9 : {2'b00, cfg.grid_width};
    assign h9 = ({2'b00, cfg.grid_height} > MAX_H9) ? MAX_H9 : {2'b00, cfg.grid_height};
    assign grid_empty = (w9 == 9'd0) || (h9 == 9'd0);

    assign dc   = (c_reg >= {2'b00, col_reg}) ? c_reg - {2'b00, col_reg}
                                              : {2'b00, col_reg} - c_reg;
    assign dr   = (r_reg >= {2'b00, row_reg}) ? r_reg - {2'b00, row_reg}
                                              : {2'b00, row_reg} - r_reg;
    assign scan_dist = {1'b0, dc} + {1'b0, dr};

    assign c9  = {1'b0, c_reg};
    assign r9  = {1'b0, r_reg};
    assign wc9 = {3'b000, cmd.col};
    assign wr9 = {3'b000, cmd.row};

    assign mem_we   = (state_reg == ST_IDLE) && !cmd_empty && (cmd.kind == KIND_WRITE);
    assign mem_addr = mem_we ? {wr9[RW-1:0], wc9[CW-1:0]} : {r9[RW-1:0], c9[CW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= cmd.symbol;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign match = s1_valid_reg && (rd_data_reg == sym_reg)
                   && ({1'b0, s1_dist_reg} < best_dist_reg);
    assign load  = (state_reg == ST_FINISH) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next      = state_reg;
        cmd_pop         = 1'b0;
        col_next        = col_reg;
        row_next        = row_reg;
        sym_next        = sym_reg;
        last_c_next     = last_c_reg;
        last_r_next     = last_r_reg;
        c_next          = c_reg;
        r_next          = r_reg;
        s1_valid_next   = 1'b0;
        s1_dist_next    = scan_dist;
        s1_c_next       = c_reg;
        s1_r_next       = r_reg;
        best_dist_next  = best_dist_reg;
        best_c_next     = best_c_reg;
        best_r_next     = best_r_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        found_next      = found_reg;
        match_col_next  = match_col_reg;
        match_row_next  = match_row_reg;
        match_dist_next = match_dist_reg;

        if (match)
        begin
            best_dist_next = {1'b0, s1_dist_reg};
            best_c_next    = s1_c_reg;
            best_r_next    = s1_r_reg;
            hit_next       = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.kind == KIND_QUERY)
                    begin
                        col_next       = cmd.col;
                        row_next       = cmd.row;
                        sym_next       = cmd.symbol;
                        last_c_next    = 8'(w9 - 9'd1);
                        last_r_next    = 8'(h9 - 9'd1);
                        c_next         = 8'd0;
                        r_next         = 8'd0;
                        best_dist_next = cfg.distance_limit;
                        best_c_next    = 8'd0;
                        best_r_next    = 8'd0;
                        hit_next       = 1'b0;
                        state_next     = grid_empty ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                s1_valid_next = 1'b1;
                if (c_reg == last_c_reg)
                begin
                    c_next = 8'd0;
                    if (r_reg == last_r_reg)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        r_next = r_reg + 8'd1;
                    end
                end
                else
                begin
                    c_next = c_reg + 8'd1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    found_next      = hit_reg;
                    match_col_next  = hit_reg ? best_c_reg[5:0] : 6'd0;
                    match_row_next  = hit_reg ? best_r_reg[5:0] : 6'd0;
                    if (!hit_reg)
                    begin
                        match_dist_next = 7'd0;
                    end
                    else if (best_dist_reg > {3'b000, DISTANCE_SAT})
                    begin
                        match_dist_next = DISTANCE_SAT;
                    end
                    else
                    begin
                        match_dist_next = best_dist_reg[6:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s1_valid_reg  <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s1_valid_reg  <= s1_valid_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        sym_reg        <= sym_next;
        last_c_reg     <= last_c_next;
        last_r_reg     <= last_r_next;
        c_reg          <= c_next;
        r_reg          <= r_next;
        s1_dist_reg    <= s1_dist_next;
        s1_c_reg       <= s1_c_next;
        s1_r_reg       <= s1_r_next;
        best_dist_reg  <= best_dist_next;
        best_c_reg     <= best_c_next;
        best_r_reg     <= best_r_next;
        found_reg      <= found_next;
        match_col_reg  <= match_col_next;
        match_row_reg  <= match_row_next;
        match_dist_reg <= match_dist_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = found_reg;
    assign result.match_col      = match_col_reg;
    assign result.match_row      = match_row_reg;
    assign result.match_distance = match_dist_reg;

    always_comb
    begin
        status.scanning = (state_reg == ST_SCAN);
        status.loading  = load;
    end

endmodule

[rtl/nearest_symbol_grid_search.sv]
// Nearest-symbol grid search top level: configuration registers, front end,
// command queue and scan engine. Depends on nsgs_pkg, the channel interfaces
// and assert_macros.svh. A write is stored as it is popped from the queue; a query
// scans the configured grid (one memory read per cell), and the engine takes no new
// command until its result is loaded. Reset clears control state and loads the
// register reset values; grid contents are undefined until written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nearest_symbol_grid_search
    import nsgs_pkg::*;
#(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    nsgs_item_if.sink              item,
    nsgs_result_if.source          result
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    q_push;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    cmd_t    q_in;
    cmd_t    q_head;
    status_t status;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDX_GRID_WIDTH:     cfg_next.grid_width     = cfg_data[6:0];
                CFG_IDX_GRID_HEIGHT:    cfg_next.grid_height    = cfg_data[6:0];
                CFG_IDX_DISTANCE_LIMIT: cfg_next.distance_limit = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width     <= GRID_WIDTH_RESET;
            cfg_reg.grid_height    <= GRID_HEIGHT_RESET;
            cfg_reg.distance_limit <= DISTANCE_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nsgs_front #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) u_front (
        .item   (item),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    nsgs_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head),
        .empty     (q_empty)
    );

    nsgs_back #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd       (q_head),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .result    (result),
        .status    (status)
    );

    `NSGS_ASSERT(a_push_has_room, q_push |-> !q_full, "Command pushed into a full queue.")
    `NSGS_ASSERT(a_no_pop_in_scan, status.scanning |-> !q_pop, "Command popped during a scan.")
    `NSGS_ASSERT(a_result_from_load, $rose(result.valid) |-> $past(status.loading), "Result without a load.")
    `NSGS_ASSERT_NEXT(a_query_blocks_pop, q_pop && (q_head.kind == KIND_QUERY), !q_pop, "Pop right after a query.")

endmodule
